/* src/qkq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qkq_pkg
// Shared types and constants of the quadrature and key press qualifier.
// ----------------------------------------------------------------------------
package qkq_pkg;

  localparam int unsigned NUM_KEYS     = 3;
  localparam int unsigned DETENT_WIDTH = 14;
  localparam int unsigned THR_WIDTH    = 16;
  localparam int unsigned TIME_WIDTH   = 32;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENCODER_KEY_LONG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_KEY_LONG  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THIRD_KEY_LONG   = 2'd2;

  localparam logic [THR_WIDTH-1:0] ENCODER_KEY_LONG_RST = 16'd900;
  localparam logic [THR_WIDTH-1:0] SECOND_KEY_LONG_RST  = 16'd700;
  localparam logic [THR_WIDTH-1:0] THIRD_KEY_LONG_RST   = 16'd1000;

  // Step per transition, indexed by {previous A, previous B, A, B}.
  localparam logic signed [1:0] STEP_TABLE [16] = '{
    2'sd0,  -2'sd1, 2'sd1,  2'sd0,
    2'sd1,  2'sd0,  2'sd0,  -2'sd1,
    -2'sd1, 2'sd0,  2'sd0,  2'sd1,
    2'sd0,  2'sd1,  -2'sd1, 2'sd0
  };

  typedef struct packed {
    logic press_short;
    logic press_long;
  } key_evt_t;

endpackage

/* src/qkq_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qkq_encoder
// X4 quadrature step accumulator with saturation and detent readout.
// ----------------------------------------------------------------------------
module qkq_encoder #(
  parameter int SUM_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   step_en,
  input  logic                                   poll,
  input  logic                                   phase_a,
  input  logic                                   phase_b,
  output logic signed [qkq_pkg::DETENT_WIDTH-1:0] detents
);

  localparam logic signed [SUM_WIDTH:0] SUM_LIM = {2'b00, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [33:0] DETENT_LIM = 34'sd8191;

  logic        [1:0]           last_pair_r;
  logic signed [SUM_WIDTH-1:0] sum_r;
  logic signed [SUM_WIDTH-1:0] sum_nxt;

  logic        [3:0]           code;
  logic signed [1:0]           step;
  logic signed [SUM_WIDTH:0]   sum_ext;
  logic signed [SUM_WIDTH:0]   sat;
  logic signed [SUM_WIDTH:0]   biased;
  logic signed [SUM_WIDTH:0]   quot;
  logic signed [SUM_WIDTH:0]   rem;
  logic signed [33:0]          quot_wide;
  logic signed [33:0]          quot_clamp;

  always_comb begin
    code    = {last_pair_r, phase_a, phase_b};
    step    = qkq_pkg::STEP_TABLE[code];
    sum_ext = {sum_r[SUM_WIDTH-1], sum_r} + {{(SUM_WIDTH-1){step[1]}}, step};
    if (sum_ext > SUM_LIM) begin
      sat = SUM_LIM;
    end else if (sum_ext < -SUM_LIM) begin
      sat = -SUM_LIM;
    end else begin
      sat = sum_ext;
    end
    // Truncation toward zero: bias negative values by 3 before the shift.
    biased = sat[SUM_WIDTH] ? sat + {{(SUM_WIDTH-1){1'b0}}, 2'b11} : sat;
    quot   = biased >>> 2;
    rem    = sat - (quot <<< 2);
    quot_wide = {{(33-SUM_WIDTH){quot[SUM_WIDTH]}}, quot};
    if (quot_wide > DETENT_LIM) begin
      quot_clamp = DETENT_LIM;
    end else if (quot_wide < -DETENT_LIM) begin
      quot_clamp = -DETENT_LIM;
    end else begin
      quot_clamp = quot_wide;
    end
    detents = quot_clamp[qkq_pkg::DETENT_WIDTH-1:0];
    sum_nxt = poll ? rem[SUM_WIDTH-1:0] : sat[SUM_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pair_r <= 2'b11;
      sum_r       <= '0;
    end else if (step_en) begin
      last_pair_r <= {phase_a, phase_b};
      sum_r       <= sum_nxt;
    end
  end

endmodule

/* src/qkq_key.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qkq_key
// Press qualifier for one active-low key: short and long press events.
// ----------------------------------------------------------------------------
module qkq_key (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               sample_en,
  input  logic                               level,
  input  logic [qkq_pkg::TIME_WIDTH-1:0]     now_ms,
  input  logic [qkq_pkg::THR_WIDTH-1:0]      long_ms,
  output qkq_pkg::key_evt_t                  evt
);

  logic                           last_level_r;
  logic [qkq_pkg::TIME_WIDTH-1:0] press_time_r;
  logic                           long_taken_r;

  logic                           press;
  logic [qkq_pkg::TIME_WIDTH-1:0] press_time_nxt;
  logic                           taken;
  logic [qkq_pkg::TIME_WIDTH-1:0] held;
  logic                           long_taken_nxt;

  always_comb begin
    press          = last_level_r && !level;
    press_time_nxt = press ? now_ms : press_time_r;
    taken          = press ? 1'b0 : long_taken_r;
    held           = now_ms - press_time_nxt;
    evt.press_long = !level && !taken &&
                     (held >= {{(qkq_pkg::TIME_WIDTH-qkq_pkg::THR_WIDTH){1'b0}}, long_ms});
    evt.press_short = !last_level_r && level && !taken;
    long_taken_nxt  = taken || evt.press_long;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= 1'b1;
      press_time_r <= '0;
      long_taken_r <= 1'b0;
    end else if (sample_en) begin
      last_level_r <= level;
      press_time_r <= press_time_nxt;
      long_taken_r <= long_taken_nxt;
    end
  end

endmodule

/* src/quadrature_and_key_press_qualifier_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_and_key_press_qualifier_core
// X4 quadrature decoder with detent readout and three-key press qualifier.
// ----------------------------------------------------------------------------
// Each input transfer is one pin sample: encoder lines, key levels, a
// millisecond timestamp and a poll flag. Every sample produces exactly one
// result transfer. On a poll sample the result carries the whole detents
// since the previous poll and the short and long events of the three keys;
// on other samples the result is all zeros. The cfg channel writes the
// three long-press thresholds and is always ready; it should only be used
// while no sample is in flight.
// Results are registered; one sample is taken every cycle while in_tready
// is high, the limit being the combinational table lookup, add, saturation
// and key compares between the sample and the result register.
// A two-entry result buffer lets a sample be taken while a result waits,
// and in_tready drops only when both entries are full.
// Reset restores the thresholds to 900, 700 and 1000 ms, clears the
// accumulator, treats the encoder lines as high and all keys as released.
// ----------------------------------------------------------------------------
module quadrature_and_key_press_qualifier_core #(
  parameter int SUM_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] phase_a, [1] phase_b, [33:2] now_ms, [34] encoder_key_level,
  // [35] second_key_level, [36] third_key_level, [39:37] zero
  input  logic [39:0]                         in_tdata,
  // [0] poll
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [13:0] detents, [14] encoder_key_short, [15] encoder_key_long,
  // [16] second_key_short, [17] second_key_long, [18] third_key_short,
  // [19] third_key_long, [23:20] zero
  output logic [23:0]                         out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qkq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qkq_pkg::THR_WIDTH-1:0]       cfg_data
);

  localparam int KEY_LVL_LSB = 34;

  logic [qkq_pkg::THR_WIDTH-1:0] thr_r [qkq_pkg::NUM_KEYS];
  logic                          accept;
  logic                          poll;
  logic signed [qkq_pkg::DETENT_WIDTH-1:0] detents;
  qkq_pkg::key_evt_t             evt [qkq_pkg::NUM_KEYS];
  logic [19:0]                   result;

  logic        out_valid_r;
  logic [19:0] out_data_r;
  logic        skid_valid_r;
  logic [19:0] skid_data_r;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_valid_r;
  assign accept    = in_tvalid && in_tready;
  assign poll      = in_tuser;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r[0] <= qkq_pkg::ENCODER_KEY_LONG_RST;
      thr_r[1] <= qkq_pkg::SECOND_KEY_LONG_RST;
      thr_r[2] <= qkq_pkg::THIRD_KEY_LONG_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        qkq_pkg::CFG_ENCODER_KEY_LONG: thr_r[0] <= cfg_data;
        qkq_pkg::CFG_SECOND_KEY_LONG:  thr_r[1] <= cfg_data;
        qkq_pkg::CFG_THIRD_KEY_LONG:   thr_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  qkq_encoder #(
    .SUM_WIDTH(SUM_WIDTH)
  ) u_encoder (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (accept),
    .poll    (poll),
    .phase_a (in_tdata[0]),
    .phase_b (in_tdata[1]),
    .detents (detents)
  );

  for (genvar k = 0; k < qkq_pkg::NUM_KEYS; k++) begin : g_key
    qkq_key u_key (
      .clk       (clk),
      .rst_n     (rst_n),
      .sample_en (accept && poll),
      .level     (in_tdata[KEY_LVL_LSB+k]),
      .now_ms    (in_tdata[33:2]),
      .long_ms   (thr_r[k]),
      .evt       (evt[k])
    );
  end

  always_comb begin
    result = '0;
    if (poll) begin
      result = {evt[2].press_long, evt[2].press_short,
                evt[1].press_long, evt[1].press_short,
                evt[0].press_long, evt[0].press_short,
                detents};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_data_r <= skid_valid_r ? skid_data_r : result;
    end else if (accept) begin
      skid_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_data_r};

endmodule
